// ===== rtl/core/cbd_pkg.sv =====
package cbd_pkg;

  localparam int CoordWidthDef   = 32;
  localparam int CordicStagesDef = 20;
  localparam int AngleFrac       = 16;
  localparam int DataW           = 64;
  localparam int GuardTop        = 60;
  localparam int ZW              = 24;
  localparam int VW              = 26;
  localparam int HeadingW        = 9;
  localparam int TableLen        = 32;

  localparam logic [HeadingW-1:0] HeadUp    = 9'd0;
  localparam logic [HeadingW-1:0] HeadRight = 9'd90;
  localparam logic [HeadingW-1:0] HeadDown  = 9'd180;
  localparam logic [HeadingW-1:0] HeadLeft  = 9'd270;
  localparam logic [HeadingW-1:0] HeadFull  = 9'd360;
  localparam logic [HeadingW-1:0] HeadMax   = 9'd359;

  typedef struct packed {
    logic                special;
    logic [HeadingW-1:0] heading;
    logic                dx_neg;
  } cbd_meta_t;

  function automatic logic signed [ZW-1:0] atan_deg(input int unsigned idx);
    logic signed [ZW-1:0] a;
    case (idx)
      0:       a = 24'sd2949120;
      1:       a = 24'sd1740967;
      2:       a = 24'sd919879;
      3:       a = 24'sd466945;
      4:       a = 24'sd234379;
      5:       a = 24'sd117304;
      6:       a = 24'sd58666;
      7:       a = 24'sd29335;
      8:       a = 24'sd14668;
      9:       a = 24'sd7334;
      10:      a = 24'sd3667;
      11:      a = 24'sd1833;
      12:      a = 24'sd917;
      13:      a = 24'sd458;
      14:      a = 24'sd229;
      15:      a = 24'sd115;
      16:      a = 24'sd57;
      17:      a = 24'sd29;
      18:      a = 24'sd14;
      19:      a = 24'sd7;
      20:      a = 24'sd4;
      21:      a = 24'sd2;
      22:      a = 24'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/core/compass_bearing_degrees.sv =====
// Returns the whole-degree heading, clockwise from +y, from the from point to the to point
// of each beat. The block is a fully pipelined unrolled CORDIC: one beat enters every
// cycle unless the output is stalled; it passes in order through two stages that form and
// classify the offsets, one stage per CORDIC iteration and two stages that round and wrap.
// The whole pipeline holds while the output beat is stalled, so in_stall_o follows
// out_stall_i whenever a result is waiting.
module compass_bearing_degrees
  import cbd_pkg::*;
#(
  parameter int COORD_WIDTH   = CoordWidthDef,
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] from_x_i,
  input  logic signed [COORD_WIDTH-1:0] from_y_i,
  input  logic signed [COORD_WIDTH-1:0] to_x_i,
  input  logic signed [COORD_WIDTH-1:0] to_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [HeadingW-1:0]           heading_deg_o
);

  logic                    en;
  logic                    valid_s [CORDIC_STAGES+1];
  logic signed [DataW-1:0] x_s     [CORDIC_STAGES+1];
  logic signed [DataW-1:0] y_s     [CORDIC_STAGES+1];
  logic signed [ZW-1:0]    z_s     [CORDIC_STAGES+1];
  cbd_meta_t               meta_s  [CORDIC_STAGES+1];

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign z_s[0]     = '0;

  cbd_prep #(
    .CoordWidth(COORD_WIDTH)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .from_x_i(from_x_i),
    .from_y_i(from_y_i),
    .to_x_i  (to_x_i),
    .to_y_i  (to_y_i),
    .valid_o (valid_s[0]),
    .x_o     (x_s[0]),
    .y_o     (y_s[0]),
    .meta_o  (meta_s[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    cbd_cordic_stage #(
      .Shift(i)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(valid_s[i]),
      .x_i    (x_s[i]),
      .y_i    (y_s[i]),
      .z_i    (z_s[i]),
      .meta_i (meta_s[i]),
      .valid_o(valid_s[i+1]),
      .x_o    (x_s[i+1]),
      .y_o    (y_s[i+1]),
      .z_o    (z_s[i+1]),
      .meta_o (meta_s[i+1])
    );
  end

  cbd_finish u_finish (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (valid_s[CORDIC_STAGES]),
    .z_i      (z_s[CORDIC_STAGES]),
    .meta_i   (meta_s[CORDIC_STAGES]),
    .valid_o  (out_valid_o),
    .heading_o(heading_deg_o)
  );

endmodule

// ===== rtl/core/cbd_prep.sv =====
module cbd_prep
  import cbd_pkg::*;
#(
  parameter int CoordWidth = CoordWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [CoordWidth-1:0] from_x_i,
  input  logic signed [CoordWidth-1:0] from_y_i,
  input  logic signed [CoordWidth-1:0] to_x_i,
  input  logic signed [CoordWidth-1:0] to_y_i,
  output logic                         valid_o,
  output logic signed [DataW-1:0]      x_o,
  output logic signed [DataW-1:0]      y_o,
  output cbd_meta_t                    meta_o
);

  localparam int Guard = GuardTop - CoordWidth;
  localparam int DW    = CoordWidth + 1;

  logic signed [DW-1:0]    dx_d, dy_d, dx_q, dy_q;
  logic                    valid_a_q;
  logic                    dx_zero, dy_zero, dx_neg;
  logic [DW-1:0]           ax;
  logic signed [DataW-1:0] x_d, y_d;
  cbd_meta_t               meta_d;

  assign dx_d = DW'(to_x_i) - DW'(from_x_i);
  assign dy_d = DW'(to_y_i) - DW'(from_y_i);

  always_comb begin
    dx_zero = (dx_q == '0);
    dy_zero = (dy_q == '0);
    dx_neg  = dx_q[DW-1];
    ax      = dx_neg ? DW'(-dx_q) : DW'(dx_q);
    x_d     = signed'({{(DataW-DW){1'b0}}, ax}) <<< Guard;
    y_d     = DataW'(dy_q) <<< Guard;
    meta_d.special = dx_zero || dy_zero;
    meta_d.dx_neg  = dx_neg;
    if (dx_zero) begin
      meta_d.heading = dy_q[DW-1] ? HeadDown : HeadUp;
    end else begin
      meta_d.heading = dx_neg ? HeadLeft : HeadRight;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_o   <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_o   <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      x_o    <= x_d;
      y_o    <= y_d;
      meta_o <= meta_d;
    end
  end

endmodule

// ===== rtl/core/cbd_cordic_stage.sv =====
module cbd_cordic_stage
  import cbd_pkg::*;
#(
  parameter int Shift = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [DataW-1:0] x_i,
  input  logic signed [DataW-1:0] y_i,
  input  logic signed [ZW-1:0]    z_i,
  input  cbd_meta_t               meta_i,
  output logic                    valid_o,
  output logic signed [DataW-1:0] x_o,
  output logic signed [DataW-1:0] y_o,
  output logic signed [ZW-1:0]    z_o,
  output cbd_meta_t               meta_o
);

  localparam logic signed [ZW-1:0] Angle = atan_deg(Shift);

  logic signed [DataW-1:0] xs, ys, x_d, y_d;
  logic signed [ZW-1:0]    z_d;

  always_comb begin
    xs = x_i >>> Shift;
    ys = y_i >>> Shift;
    if (!y_i[DataW-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + Angle;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - Angle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= x_d;
      y_o    <= y_d;
      z_o    <= z_d;
      meta_o <= meta_i;
    end
  end

endmodule

// ===== rtl/core/cbd_finish.sv =====
module cbd_finish
  import cbd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [ZW-1:0] z_i,
  input  cbd_meta_t            meta_i,
  output logic                 valid_o,
  output logic [HeadingW-1:0]  heading_o
);

  localparam int QW = VW - AngleFrac;
  localparam logic signed [VW-1:0] BaseRight =
    signed'({{(VW-HeadingW-AngleFrac){1'b0}}, HeadRight, {AngleFrac{1'b0}}});
  localparam logic signed [VW-1:0] BaseLeft =
    signed'({{(VW-HeadingW-AngleFrac){1'b0}}, HeadLeft, {AngleFrac{1'b0}}});
  localparam logic [AngleFrac-1:0] Half = {1'b1, {(AngleFrac-1){1'b0}}};
  localparam logic signed [QW-1:0] FullS = signed'(QW'(HeadFull));

  logic signed [VW-1:0]   v_d, v_q;
  cbd_meta_t              meta_q;
  logic                   valid_v_q;
  logic signed [QW-1:0]   q, qr, qw;
  logic [AngleFrac-1:0]   f;
  logic                   up;
  logic [HeadingW-1:0]    heading_d;

  assign v_d = meta_i.dx_neg ? (BaseLeft + VW'(z_i)) : (BaseRight - VW'(z_i));

  always_comb begin
    q  = v_q[VW-1:AngleFrac];
    f  = v_q[AngleFrac-1:0];
    up = (f > Half) || ((f == Half) && q[0]);
    qr = q + QW'(up);
    if (qr < 0) begin
      qw = qr + FullS;
    end else if (qr >= FullS) begin
      qw = qr - FullS;
    end else begin
      qw = qr;
    end
    heading_d = meta_q.special ? meta_q.heading : qw[HeadingW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_v_q <= 1'b0;
      valid_o   <= 1'b0;
    end else if (en_i) begin
      valid_v_q <= valid_i;
      valid_o   <= valid_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q       <= v_d;
      meta_q    <= meta_i;
      heading_o <= heading_d;
    end
  end

endmodule

// ===== rtl/core/cbd_checker.sv =====
module cbd_checker
  import cbd_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [HeadingW-1:0] heading_deg_o
);

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (heading_deg_o <= HeadMax))
    else $error("Heading beat is outside the compass range.");

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("Input stalled while the output side was free.");

  a_out_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("Stalled output beat was dropped.");

  a_out_payload_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(heading_deg_o))
    else $error("Stalled output beat changed.");

endmodule

bind compass_bearing_degrees cbd_checker u_cbd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .heading_deg_o(heading_deg_o)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb
  import cbd_pkg::*;
();

  localparam int CoordW     = CoordWidthDef;
  localparam int Stages     = CordicStagesDef;
  localparam int Latency    = Stages + 4;
  localparam int HoldCycles = 120;
  localparam int CycleLimit = 200000;

  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};

  localparam longint AtanDegQ16 [0:22] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1
  };

  typedef enum int {
    PickWide, PickNear, PickAxis, PickDiag, PickSteep, PickCorner
  } pick_e;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [CoordW-1:0] from_x_i;
  logic signed [CoordW-1:0] from_y_i;
  logic signed [CoordW-1:0] to_x_i;
  logic signed [CoordW-1:0] to_y_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [HeadingW-1:0]      heading_deg_o;

  logic [HeadingW-1:0] heading_q[$];
  logic [HeadingW-1:0] want_heading;
  bit                  src_idle_en;
  bit                  sink_idle_en;
  bit                  hold_req;
  int                  beats_sent;
  int                  headings_checked;
  int                  fail_count;
  int                  cycle_count;

  compass_bearing_degrees #(
    .COORD_WIDTH  (CoordW),
    .CORDIC_STAGES(Stages)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .from_x_i     (from_x_i),
    .from_y_i     (from_y_i),
    .to_x_i       (to_x_i),
    .to_y_i       (to_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .heading_deg_o(heading_deg_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic logic [HeadingW-1:0] predict_heading(
    logic signed [CoordW-1:0] fx, logic signed [CoordW-1:0] fy,
    logic signed [CoordW-1:0] tx, logic signed [CoordW-1:0] ty);
    longint dx, dy, cx, cy, sx, sy, ang, v, q, f, half;
    dx = longint'(tx) - longint'(fx);
    dy = longint'(ty) - longint'(fy);
    if (dx == 0) return (dy < 0) ? HeadDown : HeadUp;
    if (dy == 0) return (dx > 0) ? HeadRight : HeadLeft;
    cx = ((dx < 0) ? -dx : dx) <<< (GuardTop - CoordW);
    cy = dy <<< (GuardTop - CoordW);
    ang = 0;
    for (int i = 0; i < Stages; i++) begin
      sx = cx >>> i;
      sy = cy >>> i;
      if (cy >= 0) begin
        cx = cx + sy;
        cy = cy - sx;
        ang = ang + ((i <= 22) ? AtanDegQ16[i] : 0);
      end else begin
        cx = cx - sy;
        cy = cy + sx;
        ang = ang - ((i <= 22) ? AtanDegQ16[i] : 0);
      end
    end
    if (dx > 0) v = (longint'(HeadRight) <<< AngleFrac) - ang;
    else v = (longint'(HeadLeft) <<< AngleFrac) + ang;
    q = v >>> AngleFrac;
    f = v - (q <<< AngleFrac);
    half = longint'(1) <<< (AngleFrac - 1);
    if (f > half || (f == half && q[0])) q = q + 1;
    q = q % longint'(HeadFull);
    if (q < 0) q = q + longint'(HeadFull);
    return q[HeadingW-1:0];
  endfunction

  // The receiver drives its stall in runs; a long hold lets the pipeline fill.
  initial begin
    out_stall_i = 1'b0;
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
      end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (heading_q.size() == 0) begin
        $error("heading_deg beat with nothing expected, actual %0d", heading_deg_o);
        fail_count++;
      end else begin
        want_heading = heading_q.pop_front();
        headings_checked++;
        if (heading_deg_o !== want_heading) begin
          $error("heading_deg expected %0d actual %0d", want_heading, heading_deg_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timed out after %0d cycles with %0d headings pending.",
               cycle_count, heading_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_bearing(input logic signed [CoordW-1:0] fx,
                              input logic signed [CoordW-1:0] fy,
                              input logic signed [CoordW-1:0] tx,
                              input logic signed [CoordW-1:0] ty);
    @(negedge clk_i);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    from_x_i   <= fx;
    from_y_i   <= fy;
    to_x_i     <= tx;
    to_y_i     <= ty;
    do @(posedge clk_i); while (in_stall_o);
    heading_q.push_back(predict_heading(fx, fy, tx, ty));
    beats_sent++;
  endtask

  function automatic logic signed [CoordW-1:0] pick_edge_coord();
    case ($urandom_range(0, 4))
      0: return CoordMin;
      1: return CoordMax;
      2: return '0;
      3: return '1;
      default: return 1;
    endcase
  endfunction

  task automatic send_random_bearing();
    logic signed [CoordW-1:0] fx, fy, dx, dy;
    int mag;
    pick_e pick;
    pick = pick_e'($urandom_range(0, 5));
    fx = $urandom;
    fy = $urandom;
    dx = $urandom;
    dy = $urandom;
    case (pick)
      PickNear: begin
        dx = int'($urandom_range(0, 2000)) - 1000;
        dy = int'($urandom_range(0, 2000)) - 1000;
      end
      PickAxis: begin
        if ($urandom_range(0, 1)) dx = '0;
        else dy = '0;
      end
      PickDiag: begin
        mag = int'($urandom_range(1, 1 << 20));
        dx = $urandom_range(0, 1) ? mag : -mag;
        dy = $urandom_range(0, 1) ? mag : -mag;
      end
      PickSteep: begin
        if ($urandom_range(0, 1)) dx = int'($urandom_range(0, 6)) - 3;
        else dy = int'($urandom_range(0, 6)) - 3;
      end
      PickCorner: begin
        fx = pick_edge_coord();
        fy = pick_edge_coord();
        dx = pick_edge_coord() - fx;
        dy = pick_edge_coord() - fy;
      end
      default: ;
    endcase
    send_bearing(fx, fy, fx + dx, fy + dy);
  endtask

  task automatic test_equal_and_axis();
    send_bearing(0, 0, 0, 0);
    send_bearing(CoordMin, CoordMax, CoordMin, CoordMax);
    send_bearing(0, 0, 0, 5);
    send_bearing(0, 0, 0, -5);
    send_bearing(0, 0, 7, 0);
    send_bearing(0, 0, -7, 0);
    send_bearing(3, CoordMin, 3, CoordMax);
    send_bearing(3, CoordMax, 3, CoordMin);
    send_bearing(CoordMin, -1, CoordMax, -1);
    send_bearing(CoordMax, -1, CoordMin, -1);
  endtask

  task automatic test_corners_and_wrap();
    send_bearing(CoordMin, CoordMin, CoordMax, CoordMax);
    send_bearing(CoordMax, CoordMax, CoordMin, CoordMin);
    send_bearing(CoordMin, CoordMax, CoordMax, CoordMin);
    send_bearing(CoordMax, CoordMin, CoordMin, CoordMax);
    send_bearing(0, 0, -1, CoordMax);
    send_bearing(0, 0, 1, CoordMax);
    send_bearing(0, 0, -1, CoordMin);
    send_bearing(0, 0, 1, 1);
    send_bearing(0, 0, 1, -1);
    send_bearing(0, 0, -1, -1);
    send_bearing(0, 0, -1, 1);
    send_bearing(-1, -1, 0, 0);
  endtask

  task automatic test_random_idling(input int count);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    repeat (count) send_random_bearing();
  endtask

  task automatic test_output_hold(input int count);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    hold_req     = 1'b1;
    repeat (count) send_random_bearing();
  endtask

  task automatic test_streaming(input int count);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (count) send_random_bearing();
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    from_x_i         = '0;
    from_y_i         = '0;
    to_x_i           = '0;
    to_y_i           = '0;
    src_idle_en      = 1'b1;
    sink_idle_en     = 1'b1;
    hold_req         = 1'b0;
    beats_sent       = 0;
    headings_checked = 0;
    fail_count       = 0;
    cycle_count      = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_equal_and_axis();
    test_corners_and_wrap();
    test_random_idling(1100);
    test_output_hold(60);
    test_streaming(240);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (heading_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 8) @(posedge clk_i);

    $display("Checked %0d headings from %0d beats: equal points, axis offsets, corners,",
             headings_checked, beats_sent);
    $display("rounding wrap, random offsets with idling, a long output hold and a stream.");
    if (fail_count == 0 && heading_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/cbd_pkg.sv
rtl/core/cbd_prep.sv
rtl/core/cbd_cordic_stage.sv
rtl/core/cbd_finish.sv
rtl/core/compass_bearing_degrees.sv
rtl/core/cbd_checker.sv
bench/tb.sv
